>>> rtl/core/rde_pkg.sv
// Shared constants, status types and helper functions of the radix digit emitter.
// No dependencies; every other file of the block but rde_ram uses this package.
package rde_pkg;

    localparam int DEF_MAX_SYMBOLS = 56;
    localparam int DEF_VALUE_WIDTH = 32;

    localparam int LEN_W      = 6;
    localparam int SYM_W      = 8;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int LANE_W     = $clog2(CFG_DATA_W / SYM_W);
    localparam int BIT_W      = 3;
    localparam int FIFO_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_LENGTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_FIRST = 3'd1;

    localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;

    typedef struct packed {
        logic busy;
        logic ok;
    } tbl_status_t;

    // Number of bits a digit of the given radix needs.
    function automatic logic [BIT_W-1:0] digit_bits(input logic [LEN_W-1:0] radix);
        logic [LEN_W-1:0] top;
        logic [BIT_W-1:0] n;
        top = radix - 1'b1;
        n   = '0;
        for (int i = 0; i < LEN_W; i++)
        begin
            if (top[i])
            begin
                n = BIT_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

>>> rtl/core/rde_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module rde_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

>>> rtl/core/rde_fifo.sv
// Small first-in first-out queue built from flops, used on both sides of the back end.
// Depends on rde_pkg for the default depth.
module rde_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = rde_pkg::FIFO_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_wr;
    logic             do_rd;

    assign full    = (cnt_reg == FULL_CNT);
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

>>> rtl/core/rde_cfg.sv
// Configuration registers (radix and symbol table) and the sequential table checker.
// Depends on rde_pkg.
module rde_cfg #(
    parameter int MAX_SYMBOLS = rde_pkg::DEF_MAX_SYMBOLS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wen,
    input  logic [rde_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rde_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [rde_pkg::LEN_W-1:0]      rd_idx,
    output logic [rde_pkg::SYM_W-1:0]      rd_sym,
    output logic [rde_pkg::LEN_W-1:0]      radix,
    output rde_pkg::tbl_status_t           tbl_st
);

    import rde_pkg::*;

    localparam int SYM_ROWS = (MAX_SYMBOLS + 7) / 8;
    localparam int ROW_W    = (SYM_ROWS > 1) ? $clog2(SYM_ROWS) : 1;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_SYMBOLS);
    localparam logic [LEN_W-1:0] MIN_LEN = LEN_W'(2);

    logic [LEN_W-1:0]      base_len_reg;
    logic [CFG_DATA_W-1:0] sym_reg [SYM_ROWS];
    logic [255:0]          seen_reg;
    logic [LEN_W-1:0]      chk_idx_reg;
    logic                  busy_reg;
    logic                  ok_reg;

    logic [LEN_W-1:0]          idx;
    logic [LEN_W-LANE_W-1:0]   row;
    logic [LANE_W-1:0]         lane;
    logic [SYM_W-1:0]          cur_sym;

    assign radix       = base_len_reg;
    assign tbl_st.busy = busy_reg;
    assign tbl_st.ok   = ok_reg;

    // One read port into the table, owned by the checker while it runs.
    assign idx  = busy_reg ? chk_idx_reg : rd_idx;
    assign row  = idx[LEN_W-1:LANE_W];
    assign lane = idx[LANE_W-1:0];

    always_comb
    begin
        cur_sym = '0;
        if (int'(row) < SYM_ROWS)
        begin
            cur_sym = sym_reg[row[ROW_W-1:0]][lane*SYM_W +: SYM_W];
        end
    end

    assign rd_sym = cur_sym;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_len_reg <= '0;
        end
        else if (cfg_wen && cfg_index == REG_BASE_LENGTH)
        begin
            base_len_reg <= cfg_data[LEN_W-1:0];
        end
    end

    // Rows above the largest legal table are never stored.
    for (genvar r = 0; r < SYM_ROWS; r++)
    begin : g_row
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sym_reg[r] <= '0;
            end
            else if (cfg_wen && cfg_index == REG_SYMBOLS_FIRST + CFG_IDX_W'(r))
            begin
                sym_reg[r] <= cfg_data;
            end
        end
    end

    // Any write restarts the check; one symbol is tested against a seen map each cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            ok_reg      <= 1'b0;
            chk_idx_reg <= '0;
            seen_reg    <= '0;
        end
        else if (cfg_wen)
        begin
            busy_reg    <= 1'b1;
            ok_reg      <= 1'b1;
            chk_idx_reg <= '0;
            seen_reg    <= '0;
        end
        else if (busy_reg)
        begin
            if (base_len_reg < MIN_LEN || base_len_reg > MAX_LEN)
            begin
                ok_reg   <= 1'b0;
                busy_reg <= 1'b0;
            end
            else if (cur_sym == CH_PLUS || cur_sym == CH_MINUS || seen_reg[cur_sym])
            begin
                ok_reg   <= 1'b0;
                busy_reg <= 1'b0;
            end
            else
            begin
                seen_reg[cur_sym] <= 1'b1;
                if (chk_idx_reg == base_len_reg - 1'b1)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    chk_idx_reg <= chk_idx_reg + 1'b1;
                end
            end
        end
    end

endmodule

>>> rtl/core/rde_front.sv
// Front end: takes input items, splits them into sign and magnitude, and queues them.
// Depends on rde_pkg and rde_fifo.
module rde_front #(
    parameter int VALUE_WIDTH = rde_pkg::DEF_VALUE_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic signed [VALUE_WIDTH-1:0] value,
    output logic                          full,
    input  logic                          fe_pop,
    output logic                          fe_empty,
    output logic                          fe_neg,
    output logic [VALUE_WIDTH-1:0]        fe_mag
);

    import rde_pkg::*;

    logic [VALUE_WIDTH-1:0] raw;
    logic                   neg;
    logic [VALUE_WIDTH-1:0] mag;

    assign raw = $unsigned(value);
    assign neg = raw[VALUE_WIDTH-1];
    // The most negative value wraps to the pattern of 2^(W-1), read as unsigned.
    assign mag = neg ? (~raw + 1'b1) : raw;

    rde_fifo #(
        .WIDTH (VALUE_WIDTH + 1),
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data ({neg, mag}),
        .full    (full),
        .rd_en   (fe_pop),
        .rd_data ({fe_neg, fe_mag}),
        .empty   (fe_empty)
    );

endmodule

>>> rtl/core/rde_back.sv
// Back end: builds the powers of the radix, then peels digits most significant first
// and queues the symbols. Depends on rde_pkg, rde_ram and rde_fifo.
module rde_back #(
    parameter int VALUE_WIDTH = rde_pkg::DEF_VALUE_WIDTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      fe_empty,
    input  logic                      fe_neg,
    input  logic [VALUE_WIDTH-1:0]    fe_mag,
    output logic                      fe_pop,
    input  rde_pkg::tbl_status_t      tbl_st,
    input  logic [rde_pkg::LEN_W-1:0] radix,
    output logic [rde_pkg::LEN_W-1:0] sym_idx,
    input  logic [rde_pkg::SYM_W-1:0] sym,
    output logic                      empty,
    input  logic                      pop,
    output logic [rde_pkg::SYM_W-1:0] symbol,
    output logic                      last
);

    import rde_pkg::*;

    localparam int KW = $clog2(VALUE_WIDTH);
    localparam int PW = VALUE_WIDTH + LEN_W;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_CMP  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

    state_t                 state_reg,  state_next;
    logic [VALUE_WIDTH-1:0] rem_reg,    rem_next;
    logic [VALUE_WIDTH-1:0] p_reg,      p_next;
    logic [PW-1:0]          prod_reg,   prod_next;
    logic [KW-1:0]          k_reg,      k_next;
    logic [BIT_W-1:0]       b_reg,      b_next;
    logic [LEN_W-1:0]       q_reg,      q_next;
    logic                   sign_reg,   sign_next;

    logic                   ram_we;
    logic [KW-1:0]          ram_waddr;
    logic [VALUE_WIDTH-1:0] ram_wdata;
    logic                   ram_re;
    logic [KW-1:0]          ram_raddr;
    logic [VALUE_WIDTH-1:0] ram_rdata;

    logic                   out_wr;
    logic [SYM_W:0]         out_data;
    logic                   out_full;
    logic [PW-1:0]          trial;
    logic [BIT_W-1:0]       top_bit;

    assign sym_idx = q_reg;
    assign top_bit = digit_bits(radix) - 1'b1;
    assign trial   = PW'(ram_rdata) << b_reg;

    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        p_next     = p_reg;
        prod_next  = prod_reg;
        k_next     = k_reg;
        b_next     = b_reg;
        q_next     = q_reg;
        sign_next  = sign_reg;
        fe_pop     = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = k_reg;
        ram_wdata  = p_reg;
        ram_re     = 1'b0;
        ram_raddr  = k_reg;
        out_wr     = 1'b0;
        out_data   = {sym, 1'b0};

        // The sign goes out while the powers are being built; digits wait behind it.
        if (sign_reg && !out_full)
        begin
            out_wr    = 1'b1;
            out_data  = {CH_MINUS, 1'b0};
            sign_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (!fe_empty && !tbl_st.busy)
                begin
                    fe_pop = 1'b1;
                    if (tbl_st.ok)
                    begin
                        sign_next  = fe_neg;
                        rem_next   = fe_mag;
                        p_next     = VALUE_WIDTH'(1);
                        k_next     = '0;
                        ram_we     = 1'b1;
                        ram_waddr  = '0;
                        ram_wdata  = VALUE_WIDTH'(1);
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                prod_next  = PW'(p_reg) * PW'(radix);
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (prod_reg <= PW'(rem_reg))
                begin
                    p_next     = prod_reg[VALUE_WIDTH-1:0];
                    k_next     = k_reg + 1'b1;
                    ram_we     = 1'b1;
                    ram_waddr  = k_reg + 1'b1;
                    ram_wdata  = prod_reg[VALUE_WIDTH-1:0];
                    state_next = ST_MUL;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = k_reg;
                    b_next     = top_bit;
                    q_next     = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // Restoring step against the shifted power; the digit stays below the radix.
                if (PW'(rem_reg) >= trial)
                begin
                    rem_next = rem_reg - trial[VALUE_WIDTH-1:0];
                    q_next   = q_reg | (LEN_W'(1) << b_reg);
                end
                if (b_reg == '0)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    b_next = b_reg - 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (!sign_reg && !out_full)
                begin
                    out_wr   = 1'b1;
                    out_data = {sym, (k_reg == '0)};
                    if (k_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg - 1'b1;
                        ram_re     = 1'b1;
                        ram_raddr  = k_reg - 1'b1;
                        b_next     = top_bit;
                        q_next     = '0;
                        state_next = ST_DIV;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sign_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sign_reg  <= sign_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        p_reg    <= p_next;
        prod_reg <= prod_next;
        k_reg    <= k_next;
        b_reg    <= b_next;
        q_reg    <= q_next;
    end

    rde_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (VALUE_WIDTH)
    ) u_pow_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rde_fifo #(
        .WIDTH (SYM_W + 1),
        .DEPTH (FIFO_DEPTH)
    ) u_out_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_wr),
        .wr_data (out_data),
        .full    (out_full),
        .rd_en   (pop),
        .rd_data ({symbol, last}),
        .empty   (empty)
    );

endmodule

>>> rtl/core/radix_digit_emitter.sv
// Channel   Handshake                 Payload
// input     push / full               value (signed, VALUE_WIDTH bits)
// result    empty / pop               symbol (8 bits), last
// config    cfg_wen                   cfg_index (3 bits), cfg_data (64 bits)
//
// For an item in radix r the back end does one multiply and one compare per power of r,
// then one restoring step per digit bit and one write to queue each symbol. The sign is
// queued alongside.
// A configuration write starts a table check of the first base_length symbols; items wait.
// Reset clears the configuration registers to zero, which leaves the table invalid.
// Two-entry queues on each side of the back end let input and output stall on their own.
// Top level of the radix digit emitter; depends on rde_pkg, rde_cfg, rde_front, rde_back.
module radix_digit_emitter #(
    parameter int MAX_SYMBOLS = rde_pkg::DEF_MAX_SYMBOLS,
    parameter int VALUE_WIDTH = rde_pkg::DEF_VALUE_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  logic signed [VALUE_WIDTH-1:0]  value,
    output logic                           full,
    output logic                           empty,
    input  logic                           pop,
    output logic [rde_pkg::SYM_W-1:0]      symbol,
    output logic                           last,
    input  logic                           cfg_wen,
    input  logic [rde_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rde_pkg::CFG_DATA_W-1:0] cfg_data
);

    import rde_pkg::*;

    tbl_status_t            tbl_st;
    logic [LEN_W-1:0]       radix;
    logic [LEN_W-1:0]       sym_idx;
    logic [SYM_W-1:0]       sym;
    logic                   fe_pop;
    logic                   fe_empty;
    logic                   fe_neg;
    logic [VALUE_WIDTH-1:0] fe_mag;

    rde_cfg #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rd_idx    (sym_idx),
        .rd_sym    (sym),
        .radix     (radix),
        .tbl_st    (tbl_st)
    );

    rde_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .value    (value),
        .full     (full),
        .fe_pop   (fe_pop),
        .fe_empty (fe_empty),
        .fe_neg   (fe_neg),
        .fe_mag   (fe_mag)
    );

    rde_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .fe_empty (fe_empty),
        .fe_neg   (fe_neg),
        .fe_mag   (fe_mag),
        .fe_pop   (fe_pop),
        .tbl_st   (tbl_st),
        .radix    (radix),
        .sym_idx  (sym_idx),
        .sym      (sym),
        .empty    (empty),
        .pop      (pop),
        .symbol   (symbol),
        .last     (last)
    );

`ifndef NO_ASSERTIONS
    // An item is never taken from the front queue while the table is still being checked.
    a_no_pop_while_check: assert property (@(posedge clk) disable iff (!rst_n)
        fe_pop |-> !tbl_st.busy)
        else $error("item taken while table check runs");

    // The back end only takes items that are there.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        fe_pop |-> !fe_empty)
        else $error("front queue popped while empty");

    // Every configuration write restarts the table check.
    a_write_starts_check: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wen |=> tbl_st.busy)
        else $error("table check not started after a write");
`endif

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench of radix_digit_emitter: signed values in, character codes out.
// Depends on rde_pkg and the radix_digit_emitter RTL; needs no files or arguments.

typedef struct packed {
    logic [7:0]  code;
    logic        last;
    logic [15:0] item;
} out_char_t;

// Holds a copy of the digit table and the characters still owed by the block.
class digit_text_board;
    logic [5:0]  radix;
    logic [7:0]  digit_of [56];
    out_char_t   pending_chars[$];
    int unsigned failures;
    int unsigned items_seen;

    function new();
        radix = '0;
        foreach (digit_of[i])
        begin
            digit_of[i] = '0;
        end
        failures   = 0;
        items_seen = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] data);
        if (idx == rde_pkg::REG_BASE_LENGTH)
        begin
            radix = data[5:0];
        end
        else
        begin
            for (int k = 0; k < 8; k++)
            begin
                digit_of[(idx - rde_pkg::REG_SYMBOLS_FIRST) * 8 + k] = data[8 * k +: 8];
            end
        end
    endfunction

    function bit table_ok();
        if (radix < 2 || radix > rde_pkg::DEF_MAX_SYMBOLS)
        begin
            return 1'b0;
        end
        for (int i = 0; i < radix; i++)
        begin
            if (digit_of[i] == rde_pkg::CH_PLUS || digit_of[i] == rde_pkg::CH_MINUS)
            begin
                return 1'b0;
            end
            for (int j = i + 1; j < radix; j++)
            begin
                if (digit_of[i] == digit_of[j])
                begin
                    return 1'b0;
                end
            end
        end
        return 1'b1;
    endfunction

    // Works out the characters that one accepted value must produce.
    function void spell_value(logic signed [31:0] v);
        logic [31:0] mag;
        logic [7:0]  digits[$];
        out_char_t   c;
        items_seen++;
        if (!table_ok())
        begin
            return;
        end
        // The most negative value wraps to 2^31, which fits as an unsigned magnitude.
        mag = v[31] ? (~v + 1'b1) : v;
        do
        begin
            digits.push_front(digit_of[mag % radix]);
            mag = mag / radix;
        end
        while (mag != 0);
        c.item = items_seen[15:0];
        if (v[31])
        begin
            c.code = rde_pkg::CH_MINUS;
            c.last = 1'b0;
            pending_chars.push_back(c);
        end
        foreach (digits[i])
        begin
            c.code = digits[i];
            c.last = (i == digits.size() - 1);
            pending_chars.push_back(c);
        end
    endfunction

    function void check_char(logic [7:0] sym, logic lst);
        out_char_t want;
        if (pending_chars.size() == 0)
        begin
            failures++;
            if (failures <= 10)
            begin
                $display("unexpected character: symbol=%h last=%b", sym, lst);
            end
            return;
        end
        want = pending_chars.pop_front();
        if (want.code !== sym || want.last !== lst)
        begin
            failures++;
            if (failures <= 10)
            begin
                $display("item %0d: expected symbol=%h last=%b, got symbol=%h last=%b",
                         want.item, want.code, want.last, sym, lst);
            end
        end
    endfunction
endclass

module testbench;
    localparam int SETTLE_CYCLES = 400;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int MAX_SYM       = rde_pkg::DEF_MAX_SYMBOLS;

    logic                               clk = 1'b0;
    logic                               rst_n;
    logic                               push;
    logic signed [31:0]                 value;
    logic                               full;
    logic                               empty;
    logic                               pop;
    logic [rde_pkg::SYM_W-1:0]          symbol;
    logic                               last;
    logic                               cfg_wen;
    logic [rde_pkg::CFG_IDX_W-1:0]      cfg_index;
    logic [rde_pkg::CFG_DATA_W-1:0]     cfg_data;

    digit_text_board board = new();
    logic [7:0]      next_syms [MAX_SYM];
    int unsigned     cycles = 0;
    int unsigned     hold_cycles = 0;
    int unsigned     pop_gap = 0;
    int unsigned     pop_run = 0;
    bit              pop_calm = 1'b0;
    int unsigned     send_run = 0;
    bit              send_calm = 1'b0;

    radix_digit_emitter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .value     (value),
        .full      (full),
        .empty     (empty),
        .pop       (pop),
        .symbol    (symbol),
        .last      (last),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL radix_digit_emitter");
            $finish;
        end
    end

    // Idle gaps come in runs: some runs never idle, in others each item draws a random gap.
    function automatic int unsigned draw_gap(inout int unsigned run_left, inout bit calm);
        if (run_left == 0)
        begin
            run_left = $urandom_range(5, 40);
            calm     = ($urandom_range(0, 2) == 0);
        end
        run_left--;
        return calm ? 0 : $urandom_range(0, 9);
    endfunction

    // Result side; a long hold-off requested by the stimulus is counted down here.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                board.check_char(symbol, last);
                pop_gap = draw_gap(pop_run, pop_calm);
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                pop <= 1'b0;
            end
            else if (pop_gap > 0)
            begin
                pop_gap--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    task automatic send_value(input logic signed [31:0] v);
        int unsigned gap;
        gap = draw_gap(send_run, send_calm);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push  <= 1'b1;
        value <= v;
        do
        begin
            @(posedge clk);
        end
        while (full);
        board.spell_value(v);
    endtask

    // Waits until every owed character has come, then lets a dropped item drain too.
    task automatic settle();
        push <= 1'b0;
        while (board.pending_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        board.write_reg(idx, data);
    endtask

    // Writes every register; unused high bits of the length word carry noise.
    task automatic program_table(input logic [5:0] len);
        logic [63:0] word;
        word      = {$urandom, $urandom};
        word[5:0] = len;
        write_reg(rde_pkg::REG_BASE_LENGTH, word);
        for (int r = 0; r < 7; r++)
        begin
            for (int k = 0; k < 8; k++)
            begin
                word[8 * k +: 8] = next_syms[8 * r + k];
            end
            write_reg(rde_pkg::REG_SYMBOLS_FIRST + 3'(r), word);
        end
        cfg_wen <= 1'b0;
    endtask

    // Fills the table with distinct bytes, none of them a sign character.
    function automatic void fill_distinct();
        logic [7:0]  pool [254];
        logic [7:0]  swap;
        int unsigned n;
        int unsigned j;
        n = 0;
        for (int b = 0; b < 256; b++)
        begin
            if (8'(b) != rde_pkg::CH_PLUS && 8'(b) != rde_pkg::CH_MINUS)
            begin
                pool[n] = 8'(b);
                n++;
            end
        end
        for (int i = 0; i < MAX_SYM; i++)
        begin
            j       = $urandom_range(i, n - 1);
            swap    = pool[i];
            pool[i] = pool[j];
            pool[j] = swap;
            next_syms[i] = pool[i];
        end
    endfunction

    function automatic void fill_decimal();
        fill_distinct();
        for (int i = 0; i < 10; i++)
        begin
            next_syms[i] = "0" + 8'(i);
        end
    endfunction

    // Spans the whole byte range, from 0x00 up to 0xFF, skipping both sign characters.
    function automatic void fill_ramp();
        for (int i = 0; i < MAX_SYM; i++)
        begin
            next_syms[i] = 8'((i * 255) / 55);
        end
    endfunction

    function automatic logic [5:0] pick_table(input bit broken);
        logic [5:0]  len;
        int unsigned i;
        int unsigned j;
        fill_distinct();
        len = 6'($urandom_range(2, MAX_SYM));
        if (broken)
        begin
            case ($urandom_range(0, 3))
                0: len = 6'($urandom_range(0, 1));
                1:
                begin
                    j = $urandom_range(1, len - 1);
                    i = $urandom_range(0, j - 1);
                    next_syms[j] = next_syms[i];
                end
                2:
                begin
                    i = $urandom_range(0, len - 1);
                    next_syms[i] = $urandom_range(0, 1) ? rde_pkg::CH_PLUS
                                                        : rde_pkg::CH_MINUS;
                end
                default: len = 6'($urandom_range(MAX_SYM + 1, 63));
            endcase
        end
        return len;
    endfunction

    function automatic logic signed [31:0] pick_value(input int unsigned radix);
        logic signed [31:0] v;
        case ($urandom_range(0, 5))
            0, 1: v = $urandom;
            2:    v = $signed(32'($urandom)) >>> $urandom_range(0, 31);
            3:
            begin
                v = $urandom_range(0, radix * radix * radix);
                if ($urandom_range(0, 1))
                begin
                    v = -v;
                end
            end
            4:
            begin
                case ($urandom_range(0, 3))
                    0:       v = 32'sh7FFF_FFFF;
                    1:       v = 32'sh8000_0000;
                    2:       v = 0;
                    default: v = -1;
                endcase
            end
            default:
            begin
                v = $signed(radix) + $urandom_range(0, 2) - 1;
                if ($urandom_range(0, 1))
                begin
                    v = -v;
                end
            end
        endcase
        return v;
    endfunction

    initial
    begin
        logic [5:0] len;
        bit         broken;
        rst_n     <= 1'b0;
        push      <= 1'b0;
        value     <= '0;
        cfg_wen   <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The table after reset is empty, so nothing may come out.
        send_value(0);
        send_value(-1);
        settle();

        // Decimal; bytes past the length may repeat or hold a sign.
        fill_decimal();
        next_syms[10] = rde_pkg::CH_PLUS;
        next_syms[11] = "0";
        program_table(6'd10);
        send_value(0);
        send_value(1);
        send_value(-1);
        send_value(9);
        send_value(10);
        send_value(-10);
        send_value(32'sh7FFF_FFFF);
        send_value(32'sh8000_0000);
        settle();

        // Binary gives the longest output: a sign and 32 digits.
        next_syms[0] = "0";
        next_syms[1] = "1";
        program_table(6'd2);
        send_value(32'sh8000_0000);
        send_value(32'sh7FFF_FFFF);
        send_value(5);
        settle();

        fill_ramp();
        program_table(6'(MAX_SYM));
        send_value(55);
        send_value(56);
        send_value(-56);
        send_value(32'sh8000_0000);
        settle();

        // Broken tables: one symbol, a repeat, a plus, a minus, lengths past the top.
        program_table(6'd1);
        send_value(7);
        settle();
        fill_decimal();
        next_syms[9] = "3";
        program_table(6'd10);
        send_value(123);
        settle();
        fill_decimal();
        next_syms[5] = rde_pkg::CH_PLUS;
        program_table(6'd10);
        send_value(-45);
        settle();
        fill_ramp();
        next_syms[MAX_SYM - 1] = rde_pkg::CH_MINUS;
        program_table(6'(MAX_SYM));
        send_value(1000);
        settle();
        fill_distinct();
        program_table(6'(MAX_SYM + 1));
        send_value(99);
        settle();
        program_table(6'd63);
        send_value(-99);
        settle();

        for (int p = 0; p < 12; p++)
        begin
            broken = (p % 5 == 4);
            len    = pick_table(broken);
            if (p == 0)
            begin
                len = 6'd2;
            end
            else if (p == 1)
            begin
                len = 6'(MAX_SYM);
            end
            else if (p == 2)
            begin
                len = 6'd3;
            end
            program_table(len);
            // Stall the result side long enough for the block to stop taking items.
            if (p == 6)
            begin
                hold_cycles = 1500;
            end
            for (int n = 0; n < (broken ? 4 : 38); n++)
            begin
                send_value(pick_value(len));
            end
            settle();
        end

        if (board.failures == 0 && board.pending_chars.size() == 0)
        begin
            $display("PASS radix_digit_emitter");
        end
        else
        begin
            $display("FAIL radix_digit_emitter");
        end
        $finish;
    end
endmodule

>>> files.f
rtl/core/rde_pkg.sv
rtl/core/rde_ram.sv
rtl/core/rde_fifo.sv
rtl/core/rde_cfg.sv
rtl/core/rde_front.sv
rtl/core/rde_back.sv
rtl/core/radix_digit_emitter.sv
tb/sv/testbench.sv
